// ----- rtl/core/mlma_pkg.sv -----
// Shared types, constants and helpers of the multi-limb multiply-accumulate unit.
package mlma_pkg;

  localparam int MAX_LIMBS = 16;
  localparam int LIMB_W    = 32;
  localparam int IDX_W     = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int CNT_W     = $clog2(MAX_LIMBS + 1);
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLICAND_LIMBS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER_LIMBS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATOR_LIMBS  = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

  typedef struct packed {
    logic [LIMB_W-1:0] multiplicand_limb;
    logic [LIMB_W-1:0] multiplier_limb;
    logic [LIMB_W-1:0] accumulator_limb;
    logic              load_last;
  } mlma_in_t;

  typedef struct packed {
    logic [LIMB_W-1:0] result_limb;
    logic              result_last;
  } mlma_out_t;

  // Controls for the shared multiply-add unit.
  typedef struct packed {
    logic mul_en;     // capture a * b into the product register
    logic add_en;     // update the carry register from the sum
    logic use_prod;   // add the product register, else add zero
    logic clr_carry;  // start a new row with zero carry
  } mlma_mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_MUL,
    ST_ADD,
    ST_RIPPLE,
    ST_EMIT
  } mlma_state_t;

  // Limits a size register to the store depth and, if at_least_one is set, to at least one.
  function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic at_least_one);
    logic [CNT_W-1:0] r;
    if (32'(v) > MAX_LIMBS) begin
      r = CNT_W'(MAX_LIMBS);
    end else if (at_least_one && (v == '0)) begin
      r = CNT_W'(1);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mlma_mac.sv -----
// Shared 32x32 multiply and 64-bit add with carry register.
module mlma_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  mlma_pkg::mlma_mac_ctl_t     ctl,
  input  logic [mlma_pkg::LIMB_W-1:0] a,
  input  logic [mlma_pkg::LIMB_W-1:0] b,
  input  logic [mlma_pkg::LIMB_W-1:0] w,
  output logic [mlma_pkg::LIMB_W-1:0] sum_lo,
  output logic                        carry_nz
);
  import mlma_pkg::*;

  logic [2*LIMB_W-1:0] prod;
  logic [LIMB_W-1:0]   carry;
  logic [2*LIMB_W-1:0] addend;
  logic [2*LIMB_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= {{LIMB_W{1'b0}}, a} * {{LIMB_W{1'b0}}, b};
    end
  end

  // Product plus limb plus carry never exceeds 2^64 - 1.
  always_comb begin
    addend = ctl.use_prod ? prod : '0;
    sum    = addend + {{LIMB_W{1'b0}}, w} + {{LIMB_W{1'b0}}, carry};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= '0;
    end else if (ctl.clr_carry) begin
      carry <= '0;
    end else if (ctl.add_en) begin
      carry <= sum[2*LIMB_W-1:LIMB_W];
    end
  end

  assign sum_lo   = sum[LIMB_W-1:0];
  assign carry_nz = (carry != '0);

endmodule

// ----- rtl/core/multi_limb_multiply_accumulate_unit.sv -----
// Top level: limb stores, pass sequencer and output register of the multiply-accumulate unit.
//
// Usage: each input request carries one limb of the multiplicand, multiplier and
// accumulator, least significant first. Requests are taken one per cycle while
// the unit is loading; the request with load_last set starts the computation of
// accumulator + multiplicand * multiplier, truncated to k limbs, where k is
// accumulator_limbs clamped to 1..MAX_LIMBS. Limbs past MAX_LIMBS in one frame are
// dropped; limbs not reloaded keep their old values. The result leaves on the output
// channel as k requests, low limb first, result_last on the top one.
// A pass runs through one shared 32x32 multiplier and 64-bit adder. Each of the
// min(m, k) rows (none if n is 0) opens in ST_ROW, runs ST_MUL then ST_ADD for each
// partial product with i + j < k, then ST_RIPPLE for each carry ripple step and once
// more to close the row; a last ST_ROW ends the pass, then ST_EMIT sends one result
// limb per cycle while out_stall does not hold the output register.
// in_stall is high after the request with load_last is taken until the last result
// limb sits in the output register. Configuration writes are taken at any time but
// are meant for idle periods. out_stall holds the output register and the
// sequencer waits for it. Reset (synchronous, rst high) sets all sizes to 16,
// empties the load position and the output register; store contents stay
// undefined until loaded.
module multi_limb_multiply_accumulate_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mlma_pkg::mlma_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mlma_pkg::mlma_out_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [mlma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlma_pkg::CFG_W-1:0]     cfg_data
);
  import mlma_pkg::*;

  logic [LIMB_W-1:0] mc_store  [MAX_LIMBS];
  logic [LIMB_W-1:0] mr_store  [MAX_LIMBS];
  logic [LIMB_W-1:0] acc_store [MAX_LIMBS];
  logic [LIMB_W-1:0] work      [MAX_LIMBS];
  logic [MAX_LIMBS-1:0] work_valid;

  logic [CFG_W-1:0] multiplicand_limbs;
  logic [CFG_W-1:0] multiplier_limbs;
  logic [CFG_W-1:0] accumulator_limbs;

  logic [CNT_W-1:0] load_position;
  logic [CNT_W-1:0] m_size, n_size, k_size;
  logic [CNT_W-1:0] i, j, p;
  logic [CNT_W-1:0] i_next, j_next, p_next;

  mlma_state_t state, state_next;
  mlma_mac_ctl_t mac_ctl;

  logic             in_take;
  logic             start;
  logic [CNT_W:0]   ij_sum;
  logic [CNT_W:0]   ij_sum1;
  logic [IDX_W-1:0] work_addr;
  logic [LIMB_W-1:0] work_rd;
  logic [LIMB_W-1:0] sum_lo;
  logic             carry_nz;
  logic             work_we;
  logic             out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && in_data.load_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplicand_limbs <= SIZE_RESET;
      multiplier_limbs   <= SIZE_RESET;
      accumulator_limbs  <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MULTIPLICAND_LIMBS: multiplicand_limbs <= cfg_data;
        REG_MULTIPLIER_LIMBS:   multiplier_limbs   <= cfg_data;
        REG_ACCUMULATOR_LIMBS:  accumulator_limbs  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand stores are loaded one limb per request.
  always_ff @(posedge clk) begin
    if (in_take && (32'(load_position) < MAX_LIMBS)) begin
      mc_store[load_position[IDX_W-1:0]]  <= in_data.multiplicand_limb;
      mr_store[load_position[IDX_W-1:0]]  <= in_data.multiplier_limb;
      acc_store[load_position[IDX_W-1:0]] <= in_data.accumulator_limb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
    end else if (start) begin
      load_position <= '0;
    end else if (in_take && (32'(load_position) < MAX_LIMBS)) begin
      load_position <= load_position + CNT_W'(1);
    end
  end

  // Sizes are frozen for the whole pass.
  always_ff @(posedge clk) begin
    if (start) begin
      m_size <= clamp_size(multiplicand_limbs, 1'b0);
      n_size <= clamp_size(multiplier_limbs, 1'b0);
      k_size <= clamp_size(accumulator_limbs, 1'b1);
    end
  end

  assign ij_sum  = {1'b0, i} + {1'b0, j};
  assign ij_sum1 = ij_sum + (CNT_W+1)'(1);

  always_comb begin
    if (state == ST_ADD) begin
      work_addr = ij_sum[IDX_W-1:0];
    end else begin
      work_addr = p[IDX_W-1:0];
    end
  end

  // A work limb not yet written in this pass still reads as the accumulator limb.
  assign work_rd = work_valid[work_addr] ? work[work_addr] : acc_store[work_addr];

  mlma_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .a        (mc_store[i[IDX_W-1:0]]),
    .b        (mr_store[j[IDX_W-1:0]]),
    .w        (work_rd),
    .sum_lo   (sum_lo),
    .carry_nz (carry_nz)
  );

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      i <= '0;
    end else begin
      i <= i_next;
    end
    j <= j_next;
    p <= p_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pass sequencer.
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    p_next     = p;
    mac_ctl    = '0;
    work_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        j_next            = '0;
        mac_ctl.clr_carry = 1'b1;
        if ((i < m_size) && (i < k_size) && (n_size != '0)) begin
          state_next = ST_MUL;
        end else begin
          p_next     = '0;
          state_next = ST_EMIT;
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_next     = ST_ADD;
      end
      ST_ADD: begin
        mac_ctl.add_en   = 1'b1;
        mac_ctl.use_prod = 1'b1;
        work_we          = 1'b1;
        j_next           = j + CNT_W'(1);
        if (({1'b0, j} + (CNT_W+1)'(1) < {1'b0, n_size}) && (ij_sum1 < {1'b0, k_size})) begin
          state_next = ST_MUL;
        end else begin
          p_next     = ij_sum1[CNT_W-1:0];
          state_next = ST_RIPPLE;
        end
      end
      ST_RIPPLE: begin
        if (carry_nz && (p < k_size)) begin
          mac_ctl.add_en = 1'b1;
          work_we        = 1'b1;
          p_next         = p + CNT_W'(1);
        end else begin
          i_next     = i + CNT_W'(1);
          state_next = ST_ROW;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          p_next   = p + CNT_W'(1);
          if (p + CNT_W'(1) == k_size) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work[work_addr] <= sum_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= '0;
    end else if (start) begin
      work_valid <= '0;
    end else if (work_we) begin
      work_valid[work_addr] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.result_limb <= work_rd;
      out_data.result_last <= (p + CNT_W'(1) == k_size);
    end
  end

endmodule
